// ===== design/vector3_alu_core_defines.svh =====
// Assertion macros shared by the vector ALU core.
`ifndef VECTOR3_ALU_CORE_DEFINES_SVH
`define VECTOR3_ALU_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Concurrent check on the rising clock edge, switched off while reset is high.
`define V3A_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Concurrent check on the rising clock edge that also runs during reset.
`define V3A_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define V3A_ASSERT(lbl, clk, rst, prop, msg)
`define V3A_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== design/v3a_pkg.sv =====
// Types, constants and helper functions of the vector ALU core.
package v3a_pkg;

   // Fixed-point format and datapath widths.
   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int NUM_LANES  = 3;
   localparam int NUM_PRODS  = 2 * NUM_LANES;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int WIDE_W     = PROD_W + 2;
   localparam int SQ_W       = PROD_W;
   localparam int ROOT_W     = SQ_W / 2;
   localparam int SQ_REM_W   = ROOT_W + 2;
   localparam int SQRT_CELLS = ROOT_W;
   localparam int QUOT_W     = FRAC_BITS + 1;
   localparam int DIV_CELLS  = QUOT_W;
   localparam int DIVD_W     = DATA_W + FRAC_BITS + 1;
   localparam int MIN_NORM_W = 31;

   // Register file layout.
   localparam int PADDR_W    = 3;
   localparam int PDATA_W    = 32;
   localparam logic [PADDR_W-3:0] REG_MIN_NORM = '0;
   localparam logic [MIN_NORM_W-1:0] MIN_NORM_RESET = MIN_NORM_W'(1);

   // Saturation limits.
   localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [WIDE_W-1:0] WIDE_MAX = {{(WIDE_W-DATA_W+1){1'b0}},
                                                    {(DATA_W-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] WIDE_MIN = {{(WIDE_W-DATA_W+1){1'b1}},
                                                    {(DATA_W-1){1'b0}}};
   localparam logic signed [WIDE_W-1:0] ROUND_HALF = WIDE_W'(1) <<< (FRAC_BITS - 1);

   typedef enum logic [2:0] {
      MODE_NEG,
      MODE_ADD,
      MODE_SUB,
      MODE_SCALE,
      MODE_DOT,
      MODE_CROSS,
      MODE_NORM,
      MODE_UNIT
   } mode_type;

   // Input transaction.
   typedef struct packed {
      mode_type                   mode;
      logic signed [DATA_W-1:0]   u_x;
      logic signed [DATA_W-1:0]   u_y;
      logic signed [DATA_W-1:0]   u_z;
      logic signed [DATA_W-1:0]   v_x;
      logic signed [DATA_W-1:0]   v_y;
      logic signed [DATA_W-1:0]   v_z;
      logic signed [DATA_W-1:0]   scale;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic signed [DATA_W-1:0]   r_x;
      logic signed [DATA_W-1:0]   r_y;
      logic signed [DATA_W-1:0]   r_z;
      logic signed [DATA_W-1:0]   scalar_out;
      logic                       ok;
   } rsp_type;

   // Context carried alongside the root and divider rows.
   typedef struct packed {
      mode_type                             mode;
      logic [NUM_LANES-1:0][DATA_W-1:0]     r_pre;
      logic [DATA_W-1:0]                    sc_pre;
      logic [NUM_LANES-1:0][DATA_W-1:0]     mag;
      logic [NUM_LANES-1:0]                 neg;
   } ctx_type;

   // One slot of the square-root row.
   typedef struct packed {
      logic                   valid;
      ctx_type                ctx;
      logic [SQ_W-1:0]        s;
      logic [SQ_REM_W-1:0]    rem;
      logic [ROOT_W-1:0]      root;
   } sqrt_type;

   // One slot of the divider row, three lanes side by side.
   typedef struct packed {
      logic                                 valid;
      ctx_type                              ctx;
      logic [ROOT_W-1:0]                    n;
      logic [NUM_LANES-1:0][ROOT_W-1:0]     rem;
      logic [NUM_LANES-1:0][QUOT_W-1:0]     low;
      logic [NUM_LANES-1:0][QUOT_W-1:0]     q;
   } div_type;

   // Sign-extend a component to the wide sum width.
   function automatic logic signed [WIDE_W-1:0] wide_d(input logic signed [DATA_W-1:0] x);
      return {{(WIDE_W-DATA_W){x[DATA_W-1]}}, x};
   endfunction

   // Sign-extend a product to the wide sum width.
   function automatic logic signed [WIDE_W-1:0] wide_p(input logic signed [PROD_W-1:0] x);
      return {{(WIDE_W-PROD_W){x[PROD_W-1]}}, x};
   endfunction

   // Clamp a wide value to the Q range.
   function automatic logic signed [DATA_W-1:0] sat_q(input logic signed [WIDE_W-1:0] x);
      logic signed [DATA_W-1:0] res;
      if (x > WIDE_MAX) begin
         res = Q_MAX;
      end else if (x < WIDE_MIN) begin
         res = Q_MIN;
      end else begin
         res = x[DATA_W-1:0];
      end
      return res;
   endfunction

   // Round half up a sum of products back to Q format, then clamp.
   function automatic logic signed [DATA_W-1:0] round_q(input logic signed [WIDE_W-1:0] x);
      logic signed [WIDE_W-1:0] shifted;
      shifted = (x + ROUND_HALF) >>> FRAC_BITS;
      return sat_q(shifted);
   endfunction

endpackage

// ===== design/v3a_arith.sv =====
// Front end: input register, multiplier bank and the add, round and clamp stage.
module v3a_arith (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               req_valid,
   input  v3a_pkg::req_type   req_data,
   output v3a_pkg::sqrt_type  sqrt_head
);

   logic                                   valid0_ff;
   v3a_pkg::req_type                       req0_ff;
   logic signed [v3a_pkg::DATA_W-1:0]      op_a_in [v3a_pkg::NUM_PRODS];
   logic signed [v3a_pkg::DATA_W-1:0]      op_b_in [v3a_pkg::NUM_PRODS];
   logic signed [v3a_pkg::PROD_W-1:0]      prod_in [v3a_pkg::NUM_PRODS];
   logic                                   valid1_ff;
   v3a_pkg::req_type                       req1_ff;
   logic signed [v3a_pkg::PROD_W-1:0]      prod_ff [v3a_pkg::NUM_PRODS];
   logic signed [v3a_pkg::DATA_W-1:0]      u_vec [v3a_pkg::NUM_LANES];
   logic signed [v3a_pkg::DATA_W-1:0]      v_vec [v3a_pkg::NUM_LANES];
   logic signed [v3a_pkg::WIDE_W-1:0]      dot_sum;
   logic signed [v3a_pkg::WIDE_W-1:0]      cross_sum [v3a_pkg::NUM_LANES];
   logic                                   head_valid_ff;
   v3a_pkg::sqrt_type                      head_in;
   v3a_pkg::sqrt_type                      head_ff;

   // The input register takes a transaction whenever the pipeline moves.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else if (advance) begin
         valid0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         req0_ff <= req_data;
      end
   end

   // Operand selection for the six multipliers. The upper three always form
   // the subtracted terms of the cross product.
   always_comb begin
      op_a_in[3] = req0_ff.u_z;
      op_b_in[3] = req0_ff.v_y;
      op_a_in[4] = req0_ff.u_x;
      op_b_in[4] = req0_ff.v_z;
      op_a_in[5] = req0_ff.u_y;
      op_b_in[5] = req0_ff.v_x;
      case (req0_ff.mode)
         v3a_pkg::MODE_SCALE: begin
            op_a_in[0] = req0_ff.u_x;
            op_a_in[1] = req0_ff.u_y;
            op_a_in[2] = req0_ff.u_z;
            op_b_in[0] = req0_ff.scale;
            op_b_in[1] = req0_ff.scale;
            op_b_in[2] = req0_ff.scale;
         end
         v3a_pkg::MODE_DOT: begin
            op_a_in[0] = req0_ff.u_x;
            op_a_in[1] = req0_ff.u_y;
            op_a_in[2] = req0_ff.u_z;
            op_b_in[0] = req0_ff.v_x;
            op_b_in[1] = req0_ff.v_y;
            op_b_in[2] = req0_ff.v_z;
         end
         v3a_pkg::MODE_CROSS: begin
            op_a_in[0] = req0_ff.u_y;
            op_b_in[0] = req0_ff.v_z;
            op_a_in[1] = req0_ff.u_z;
            op_b_in[1] = req0_ff.v_x;
            op_a_in[2] = req0_ff.u_x;
            op_b_in[2] = req0_ff.v_y;
         end
         default: begin
            // Squares of u for the norm.
            op_a_in[0] = req0_ff.u_x;
            op_a_in[1] = req0_ff.u_y;
            op_a_in[2] = req0_ff.u_z;
            op_b_in[0] = req0_ff.u_x;
            op_b_in[1] = req0_ff.u_y;
            op_b_in[2] = req0_ff.u_z;
         end
      endcase
      for (int i = 0; i < v3a_pkg::NUM_PRODS; i++) begin
         prod_in[i] = op_a_in[i] * op_b_in[i];
      end
   end

   // Product register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (advance) begin
         valid1_ff <= valid0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         req1_ff <= req0_ff;
         for (int i = 0; i < v3a_pkg::NUM_PRODS; i++) begin
            prod_ff[i] <= prod_in[i];
         end
      end
   end

   // Sums, rounding and clamping; also the sum of squares and the magnitudes
   // that the root and divider rows need.
   always_comb begin
      u_vec[0] = req1_ff.u_x;
      u_vec[1] = req1_ff.u_y;
      u_vec[2] = req1_ff.u_z;
      v_vec[0] = req1_ff.v_x;
      v_vec[1] = req1_ff.v_y;
      v_vec[2] = req1_ff.v_z;
      dot_sum = v3a_pkg::wide_p(prod_ff[0]) + v3a_pkg::wide_p(prod_ff[1])
              + v3a_pkg::wide_p(prod_ff[2]);
      head_in = '0;
      head_in.valid = valid1_ff;
      head_in.ctx.mode = req1_ff.mode;
      head_in.s = $unsigned(prod_ff[0]) + $unsigned(prod_ff[1]) + $unsigned(prod_ff[2]);
      for (int i = 0; i < v3a_pkg::NUM_LANES; i++) begin
         cross_sum[i] = v3a_pkg::wide_p(prod_ff[i])
                      - v3a_pkg::wide_p(prod_ff[i+v3a_pkg::NUM_LANES]);
         head_in.ctx.neg[i] = u_vec[i][v3a_pkg::DATA_W-1];
         head_in.ctx.mag[i] = u_vec[i][v3a_pkg::DATA_W-1] ? (~u_vec[i] + 1'b1) : u_vec[i];
      end
      case (req1_ff.mode)
         v3a_pkg::MODE_NEG: begin
            for (int i = 0; i < v3a_pkg::NUM_LANES; i++) begin
               head_in.ctx.r_pre[i] = v3a_pkg::sat_q(-v3a_pkg::wide_d(u_vec[i]));
            end
         end
         v3a_pkg::MODE_ADD: begin
            for (int i = 0; i < v3a_pkg::NUM_LANES; i++) begin
               head_in.ctx.r_pre[i] = v3a_pkg::sat_q(v3a_pkg::wide_d(u_vec[i])
                                                   + v3a_pkg::wide_d(v_vec[i]));
            end
         end
         v3a_pkg::MODE_SUB: begin
            for (int i = 0; i < v3a_pkg::NUM_LANES; i++) begin
               head_in.ctx.r_pre[i] = v3a_pkg::sat_q(v3a_pkg::wide_d(u_vec[i])
                                                   - v3a_pkg::wide_d(v_vec[i]));
            end
         end
         v3a_pkg::MODE_SCALE: begin
            for (int i = 0; i < v3a_pkg::NUM_LANES; i++) begin
               head_in.ctx.r_pre[i] = v3a_pkg::round_q(v3a_pkg::wide_p(prod_ff[i]));
            end
         end
         v3a_pkg::MODE_DOT: begin
            head_in.ctx.sc_pre = v3a_pkg::round_q(dot_sum);
         end
         v3a_pkg::MODE_CROSS: begin
            for (int i = 0; i < v3a_pkg::NUM_LANES; i++) begin
               head_in.ctx.r_pre[i] = v3a_pkg::round_q(cross_sum[i]);
            end
         end
         default: begin
            // Norm and unit results are filled in after the root row.
         end
      endcase
   end

   // Head of the square-root row.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
      end else if (advance) begin
         head_valid_ff <= head_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         head_ff <= head_in;
      end
   end

   always_comb begin
      sqrt_head = head_ff;
      sqrt_head.valid = head_valid_ff;
   end

endmodule

// ===== design/v3a_sqrt_cell.sv =====
// One cell of the square-root row: settles one root bit per cycle while the pipeline advances.
module v3a_sqrt_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  v3a_pkg::sqrt_type  up_stage,
   output v3a_pkg::sqrt_type  dn_stage
);

   logic [v3a_pkg::SQ_REM_W+1:0]  rem_shift;
   logic [v3a_pkg::SQ_REM_W+1:0]  trial;
   logic [v3a_pkg::SQ_REM_W+1:0]  diff;
   logic                          take;
   logic                          valid_ff;
   v3a_pkg::sqrt_type             stage_in;
   v3a_pkg::sqrt_type             stage_ff;

   // Bring down the next two radicand bits and try the next root bit.
   always_comb begin
      rem_shift = {up_stage.rem, up_stage.s[v3a_pkg::SQ_W-1 -: 2]};
      trial     = {2'b00, up_stage.root, 2'b01};
      diff      = rem_shift - trial;
      take      = (rem_shift >= trial);
      stage_in  = up_stage;
      stage_in.s    = {up_stage.s[v3a_pkg::SQ_W-3:0], 2'b00};
      stage_in.rem  = take ? diff[v3a_pkg::SQ_REM_W-1:0] : rem_shift[v3a_pkg::SQ_REM_W-1:0];
      stage_in.root = {up_stage.root[v3a_pkg::ROOT_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   always_comb begin
      dn_stage = stage_ff;
      dn_stage.valid = valid_ff;
   end

endmodule

// ===== design/v3a_div_cell.sv =====
// One cell of the divider row: one quotient bit per cycle in each of three lanes while the pipeline advances.
module v3a_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  v3a_pkg::div_type  up_stage,
   output v3a_pkg::div_type  dn_stage
);

   logic [v3a_pkg::ROOT_W:0]  rem_shift [v3a_pkg::NUM_LANES];
   logic [v3a_pkg::ROOT_W:0]  diff [v3a_pkg::NUM_LANES];
   logic                      take [v3a_pkg::NUM_LANES];
   logic                      valid_ff;
   v3a_pkg::div_type          stage_in;
   v3a_pkg::div_type          stage_ff;

   // Restoring step: shift in the next dividend bit and subtract the norm
   // where it fits.
   always_comb begin
      stage_in = up_stage;
      for (int i = 0; i < v3a_pkg::NUM_LANES; i++) begin
         rem_shift[i] = {up_stage.rem[i], up_stage.low[i][v3a_pkg::QUOT_W-1]};
         diff[i]      = rem_shift[i] - {1'b0, up_stage.n};
         take[i]      = (rem_shift[i] >= {1'b0, up_stage.n});
         stage_in.rem[i] = take[i] ? diff[i][v3a_pkg::ROOT_W-1:0]
                                   : rem_shift[i][v3a_pkg::ROOT_W-1:0];
         stage_in.low[i] = {up_stage.low[i][v3a_pkg::QUOT_W-2:0], 1'b0};
         stage_in.q[i]   = {up_stage.q[i][v3a_pkg::QUOT_W-2:0], take[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   always_comb begin
      dn_stage = stage_ff;
      dn_stage.valid = valid_ff;
   end

endmodule

// ===== design/vector3_alu_core.sv =====
// Top level of the vector ALU core: cell rows, result stage and register port.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  req_data  (v3a_pkg::req_type)
//   rsp_      out        rsp_valid / rsp_stall  rsp_data  (v3a_pkg::rsp_type)
//   APB       in         psel / penable         paddr, pwdata, prdata
//
// One transaction enters per clock while req_stall is low; each result reaches the output
// register through the three front-end stages, the 32-cell square-root row, the divider
// set-up stage and the 17-cell divider row.
// Every mode runs the full length, so results leave in arrival order.
// Reset is synchronous: it empties the pipeline and sets min_norm to 1.
// A stalled result is held in the output register, a second one in the skid
// register; only when the skid register is full is req_stall raised.
`include "vector3_alu_core_defines.svh"
module vector3_alu_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  v3a_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output v3a_pkg::rsp_type                  rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [v3a_pkg::PADDR_W-1:0]       paddr,
   input  logic [v3a_pkg::PDATA_W-1:0]       pwdata,
   output logic [v3a_pkg::PDATA_W-1:0]       prdata,
   output logic                              pready
);

   logic                                  advance;
   logic                                  take;
   logic                                  csr_write;
   logic [v3a_pkg::MIN_NORM_W-1:0]        min_norm_ff;
   v3a_pkg::sqrt_type                     sqrt_chain [v3a_pkg::SQRT_CELLS+1];
   v3a_pkg::div_type                      div_chain [v3a_pkg::DIV_CELLS+1];
   v3a_pkg::sqrt_type                     root_end;
   logic [v3a_pkg::DIVD_W-1:0]            dividend [v3a_pkg::NUM_LANES];
   logic                                  prep_valid_ff;
   v3a_pkg::div_type                      prep_in;
   v3a_pkg::div_type                      prep_ff;
   v3a_pkg::div_type                      div_end;
   logic                                  unit_fail;
   logic [v3a_pkg::DATA_W-1:0]            quot_ext [v3a_pkg::NUM_LANES];
   logic [v3a_pkg::DATA_W-1:0]            unit_r [v3a_pkg::NUM_LANES];
   v3a_pkg::rsp_type                      final_rsp;
   logic                                  rsp_valid_ff;
   logic                                  rsp_valid_in;
   v3a_pkg::rsp_type                      rsp_data_ff;
   v3a_pkg::rsp_type                      rsp_data_in;
   logic                                  skid_valid_ff;
   logic                                  skid_valid_in;
   v3a_pkg::rsp_type                      skid_data_ff;
   v3a_pkg::rsp_type                      skid_data_in;

   // The pipeline moves as long as the skid register is free.
   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign take      = rsp_valid_ff && !rsp_stall;

   // Register port.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                   && (paddr[v3a_pkg::PADDR_W-1:2] == v3a_pkg::REG_MIN_NORM);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_norm_ff <= v3a_pkg::MIN_NORM_RESET;
      end else if (csr_write) begin
         min_norm_ff <= pwdata[v3a_pkg::MIN_NORM_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[v3a_pkg::PADDR_W-1:2] == v3a_pkg::REG_MIN_NORM) begin
         prdata = v3a_pkg::PDATA_W'(min_norm_ff);
      end
   end

   // Front end: input register, multipliers, sums.
   v3a_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_valid (req_valid),
      .req_data  (req_data),
      .sqrt_head (sqrt_chain[0])
   );

   // Square-root row.
   for (genvar k = 0; k < v3a_pkg::SQRT_CELLS; k++) begin : g_sqrt
      v3a_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .up_stage (sqrt_chain[k]),
         .dn_stage (sqrt_chain[k+1])
      );
   end

   // Divider set-up: the rounding offset of half the norm is added to each
   // scaled magnitude; the top bits start the remainder.
   always_comb begin
      root_end = sqrt_chain[v3a_pkg::SQRT_CELLS];
      prep_in  = '0;
      prep_in.valid = root_end.valid;
      prep_in.ctx   = root_end.ctx;
      prep_in.n     = root_end.root;
      if ((root_end.ctx.mode == v3a_pkg::MODE_NORM) ||
          (root_end.ctx.mode == v3a_pkg::MODE_UNIT)) begin
         prep_in.ctx.sc_pre = root_end.root[v3a_pkg::ROOT_W-1] ? v3a_pkg::Q_MAX
                                                               : root_end.root;
      end
      for (int i = 0; i < v3a_pkg::NUM_LANES; i++) begin
         dividend[i] = {1'b0, root_end.ctx.mag[i], {v3a_pkg::FRAC_BITS{1'b0}}}
                     + v3a_pkg::DIVD_W'(root_end.root >> 1);
         prep_in.rem[i] = dividend[i][v3a_pkg::DIVD_W-1:v3a_pkg::QUOT_W];
         prep_in.low[i] = dividend[i][v3a_pkg::QUOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (advance) begin
         prep_valid_ff <= prep_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prep_ff <= prep_in;
      end
   end

   always_comb begin
      div_chain[0] = prep_ff;
      div_chain[0].valid = prep_valid_ff;
   end

   // Divider row.
   for (genvar k = 0; k < v3a_pkg::DIV_CELLS; k++) begin : g_div
      v3a_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .up_stage (div_chain[k]),
         .dn_stage (div_chain[k+1])
      );
   end

   // Result assembly. A unit vector fails when the norm is zero or below
   // min_norm; the quotient never exceeds one, so no clamping is needed.
   always_comb begin
      div_end   = div_chain[v3a_pkg::DIV_CELLS];
      unit_fail = (div_end.n == '0) || (div_end.n < {1'b0, min_norm_ff});
      for (int i = 0; i < v3a_pkg::NUM_LANES; i++) begin
         quot_ext[i] = v3a_pkg::DATA_W'(div_end.q[i]);
         unit_r[i]   = div_end.ctx.neg[i] ? (~quot_ext[i] + 1'b1) : quot_ext[i];
      end
      final_rsp.r_x        = div_end.ctx.r_pre[0];
      final_rsp.r_y        = div_end.ctx.r_pre[1];
      final_rsp.r_z        = div_end.ctx.r_pre[2];
      final_rsp.scalar_out = div_end.ctx.sc_pre;
      final_rsp.ok         = 1'b1;
      if (div_end.ctx.mode == v3a_pkg::MODE_UNIT) begin
         final_rsp.ok = !unit_fail;
         if (!unit_fail) begin
            final_rsp.r_x = unit_r[0];
            final_rsp.r_y = unit_r[1];
            final_rsp.r_z = unit_r[2];
         end
      end
   end

   // Output register and skid register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!rsp_valid_ff || take) begin
         rsp_valid_in = div_end.valid;
         rsp_data_in  = final_rsp;
      end else if (div_end.valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = final_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The skid register only fills behind a waiting result.
   `V3A_ASSERT(a_skid_behind_out, clock, reset, skid_valid_ff |-> rsp_valid_ff, "skid full with empty output register")
   // A failed unit vector is the zero vector.
   `V3A_ASSERT(a_fail_zero, clock, reset, (rsp_valid_ff && !rsp_data_ff.ok) |-> ((rsp_data_ff.r_x == 0) && (rsp_data_ff.r_y == 0) && (rsp_data_ff.r_z == 0)), "failed result carries a non-zero vector")
   // Reset leaves both result registers empty.
   `V3A_ASSERT_NR(a_reset_empty, clock, $past(reset) |-> (!rsp_valid_ff && !skid_valid_ff), "result registers not empty after reset")

endmodule
